// ----- hdl/xcr_pkg.sv -----
`default_nettype none

package xcr_pkg;

  // Build defaults
  localparam int MaxBlockDef  = 1024;
  localparam int AddrBitsDef  = 24;
  localparam int ShortBlock   = 128;

  // Port field widths
  localparam int LimitW       = 21;
  localparam int OutAddrW     = 24;
  localparam logic [LimitW-1:0] LimitRst = LimitW'(65536);

  // Result queue depth (power of two, at least two)
  localparam int OutDepth     = 4;

  // Protocol bytes
  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;

  typedef enum logic [2:0] {
    PhFirst   = 3'd0,
    PhHeader  = 3'd1,
    PhBlockNo = 3'd2,
    PhCompl   = 3'd3,
    PhData    = 3'd4,
    PhCheck   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KindTx      = 2'd0,
    KindPayload = 2'd1,
    KindEnd     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EndNone   = 2'd0,
    EndEot    = 2'd1,
    EndCancel = 2'd2
  } end_e;

  // One result beat
  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            tx_byte;
    logic [7:0]            payload_byte;
    logic [OutAddrW-1:0]   payload_address;
    end_e                  end_code;
    logic [7:0]            block_number;
    logic                  last;
  } res_t;

  // Up to two results produced by one input beat
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } res_push_t;

endpackage

`default_nettype wire

// ----- hdl/xcr_core.sv -----
`default_nettype none

module xcr_core #(
  parameter int MaxBlock = xcr_pkg::MaxBlockDef,
  parameter int AddrBits = xcr_pkg::AddrBitsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic                      mode_i,
  input  wire logic [7:0]                rx_byte_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [xcr_pkg::LimitW-1:0] cfg_wdata_i,
  output xcr_pkg::res_push_t             push_o
);
  import xcr_pkg::*;

  localparam int CntW = $clog2(MaxBlock + 1);
  localparam int CmpW = ((AddrBits > LimitW) ? AddrBits : LimitW) + 1;
  localparam int ExtW = (AddrBits > OutAddrW) ? AddrBits : OutAddrW;
  localparam logic [AddrBits-1:0] AddrMax = '1;

  phase_e               phase_q, phase_d;
  logic                 long_q, long_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [7:0]           sum_q, sum_d;
  logic [AddrBits-1:0]  waddr_q, waddr_d;
  logic [7:0]           blk_q, blk_d;
  logic                 fin_q, fin_d;
  logic [LimitW-1:0]    limit_q;

  logic [CntW-1:0]      blk_len;
  logic [CntW-1:0]      count_inc;
  logic [AddrBits:0]    data_sum;
  logic [AddrBits-1:0]  data_addr;
  logic [ExtW-1:0]      data_addr_ext;
  logic [AddrBits:0]    adv_sum;
  logic                 crosses;
  res_t                 blank;

  // Block length, byte address and limit check
  always_comb begin
    blk_len       = long_q ? CntW'(MaxBlock) : CntW'(ShortBlock);
    count_inc     = count_q + 1'b1;
    data_sum      = {1'b0, waddr_q} + (AddrBits + 1)'(count_q);
    data_addr     = data_sum[AddrBits] ? AddrMax : data_sum[AddrBits-1:0];
    data_addr_ext = ExtW'(data_addr);
    adv_sum       = {1'b0, waddr_q} + (AddrBits + 1)'(blk_len);
    crosses       = (CmpW'(waddr_q) + CmpW'(blk_len)) > CmpW'(limit_q);
  end

  // Next state and results
  always_comb begin
    phase_d = phase_q;
    long_d  = long_q;
    count_d = count_q;
    sum_d   = sum_q;
    waddr_d = waddr_q;
    blk_d   = blk_q;
    fin_d   = fin_q;

    blank = '{kind: KindTx, tx_byte: 8'h00, payload_byte: 8'h00,
              payload_address: '0, end_code: EndNone,
              block_number: blk_q, last: 1'b1};
    push_o.v0 = 1'b0;
    push_o.v1 = 1'b0;
    push_o.r0 = blank;
    push_o.r1 = blank;

    if (accept_i && !fin_q) begin
      if (mode_i) begin
        if (phase_q == PhFirst) begin
          push_o.v0         = 1'b1;
          push_o.r0.tx_byte = ChNak;
        end
      end else begin
        case (phase_q)
          PhFirst, PhHeader: begin
            phase_d = PhHeader;
            if (rx_byte_i == ChCan || rx_byte_i == ChEot) begin
              fin_d              = 1'b1;
              push_o.v0          = 1'b1;
              push_o.r0.kind     = KindEnd;
              push_o.r0.end_code = (rx_byte_i == ChEot) ? EndEot : EndCancel;
            end else if (rx_byte_i == ChSoh || rx_byte_i == ChStx) begin
              long_d  = (rx_byte_i == ChStx);
              phase_d = PhBlockNo;
            end
          end
          PhBlockNo: begin
            blk_d   = rx_byte_i;
            phase_d = PhCompl;
          end
          PhCompl: begin
            sum_d   = 8'h00;
            count_d = '0;
            phase_d = PhData;
          end
          PhData: begin
            push_o.v0                 = 1'b1;
            push_o.r0.kind            = KindPayload;
            push_o.r0.payload_byte    = rx_byte_i;
            push_o.r0.payload_address = data_addr_ext[OutAddrW-1:0];
            sum_d   = sum_q + rx_byte_i;
            count_d = count_inc;
            if (count_inc >= blk_len) begin
              phase_d = PhCheck;
            end
          end
          PhCheck: begin
            push_o.v0 = 1'b1;
            if (rx_byte_i == sum_q) begin
              if (crosses) begin
                // cancel first, then acknowledge
                push_o.r0.tx_byte = ChCan;
                push_o.r0.last    = 1'b0;
                push_o.v1         = 1'b1;
                push_o.r1.tx_byte = ChAck;
              end else begin
                push_o.r0.tx_byte = ChAck;
              end
              waddr_d = adv_sum[AddrBits] ? AddrMax : adv_sum[AddrBits-1:0];
            end else begin
              push_o.r0.tx_byte = ChNak;
            end
            count_d = '0;
            sum_d   = 8'h00;
            phase_d = PhHeader;
          end
          default: begin
            phase_d = PhHeader;
          end
        endcase
      end
    end
  end

  // Transfer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      long_q  <= 1'b0;
      count_q <= '0;
      sum_q   <= 8'h00;
      waddr_q <= '0;
      blk_q   <= 8'h00;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      long_q  <= long_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      waddr_q <= waddr_d;
      blk_q   <= blk_d;
      fin_q   <= fin_d;
    end
  end

  // Flash limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/xcr_out_fifo.sv -----
`default_nettype none

module xcr_out_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire xcr_pkg::res_push_t push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output xcr_pkg::res_t           head_o
);
  import xcr_pkg::*;

  localparam int PtrW   = $clog2(OutDepth);
  localparam int CountW = $clog2(OutDepth + 1);

  res_t              mem_q [OutDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic [PtrW-1:0]   wr_ptr_nxt;
  logic              pop;
  logic [CountW-1:0] push_n;

  // Queue control
  always_comb begin
    pop        = (count_q != '0) && !out_stall_i;
    push_n     = CountW'(push_i.v0) + CountW'(push_i.v1);
    wr_ptr_nxt = wr_ptr_q + 1'b1;
    wr_ptr_d   = wr_ptr_q + PtrW'(push_n);
    rd_ptr_d   = pop ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d    = count_q + push_n - CountW'(pop);
  end

  // One beat may bring two results, so keep two slots free
  assign room_o      = (count_q <= CountW'(OutDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage
  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_ptr_nxt] <= push_i.r1;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/xmodem_checksum_receiver.sv -----
`default_nettype none

// XMODEM checksum receiver: one received byte or poll tick per input beat.
// A result is registered in the result queue and offered on the output from there.
// Throughput: one input beat per cycle; a cancel-plus-ack answer takes two
// output beats, and input stalls while fewer than two result slots are free.
// Reset (async, active low): waiting for the first byte, flash limit 65536,
// address and block state zero, result queue empty.
module xmodem_checksum_receiver #(
  parameter int MaxBlock = xcr_pkg::MaxBlockDef,
  parameter int AddrBits = xcr_pkg::AddrBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [xcr_pkg::LimitW-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        mode_i,
  input  wire logic [7:0]                  rx_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       kind_o,
  output logic [7:0]                       tx_byte_o,
  output logic [7:0]                       payload_byte_o,
  output logic [xcr_pkg::OutAddrW-1:0]     payload_address_o,
  output logic [1:0]                       end_code_o,
  output logic [7:0]                       block_number_o,
  output logic                             last_o
);
  import xcr_pkg::*;

  res_push_t push;
  res_t      head;
  logic      room;
  logic      accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  xcr_core #(
    .MaxBlock (MaxBlock),
    .AddrBits (AddrBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push)
  );

  xcr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  // Result beat fields
  assign kind_o            = head.kind;
  assign tx_byte_o         = head.tx_byte;
  assign payload_byte_o    = head.payload_byte;
  assign payload_address_o = head.payload_address;
  assign end_code_o        = head.end_code;
  assign block_number_o    = head.block_number;
  assign last_o            = head.last;

endmodule

`default_nettype wire
